@@ sv/skmm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo keypoint match mask package
// Shared types, sizes and register codes for the match mask unit.
// ----------------------------------------------------------------------------
package skmm_pkg;

    localparam int MAX_RIGHT_POINTS = 64;
    localparam int IDX_W            = $clog2(MAX_RIGHT_POINTS);
    localparam int CNT_W            = 7;
    localparam int MASK_W           = 64;

    localparam logic [14:0] FULL_TURN = 15'd23040;

    // Register indexes on the configuration port (paddr[3:2]).
    localparam logic [1:0] REG_MAX_Y     = 2'd0;
    localparam logic [1:0] REG_MAX_ANGLE = 2'd1;
    localparam logic [1:0] REG_MAX_RATIO = 2'd2;

    // Item codes.
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [5:0]       slot;
        logic [15:0]      x;
        logic [15:0]      y;
        logic [14:0]      angle;
        logic [15:0]      size;
        logic [CNT_W-1:0] count;
    } t_item;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] angle;
        logic [15:0] size;
    } t_entry;

    typedef struct packed {
        logic [15:0] max_y;
        logic [13:0] max_angle;
        logic [11:0] max_ratio;
    } t_cfg;

endpackage
`default_nettype wire

@@ sv/skmm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Match mask front end
// Accepts items, folds the angle, clamps the count and queues them.
// ----------------------------------------------------------------------------
module skmm_front
    import skmm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         i_action,
    input  wire  [5:0]  i_slot,
    input  wire  [15:0] i_point_x,
    input  wire  [15:0] i_point_y,
    input  wire  [14:0] i_point_angle,
    input  wire  [15:0] i_point_size,
    input  wire  [6:0]  i_right_count,
    output logic        o_busy,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  wire         i_q_pop
);

    t_item       r_q [2];
    logic        r_wptr, n_wptr;
    logic        r_rptr, n_rptr;
    logic [1:0]  r_cnt,  n_cnt;
    t_item       w_item;
    logic        w_push;
    logic        w_pop;

    always_comb begin
        w_item        = '0;
        w_item.action = i_action;
        w_item.slot   = i_slot;
        w_item.x      = i_point_x;
        w_item.y      = i_point_y;
        w_item.size   = i_point_size;
        // An angle of a full turn or more is reduced once.
        if (i_point_angle >= FULL_TURN) begin
            w_item.angle = i_point_angle - FULL_TURN;
        end else begin
            w_item.angle = i_point_angle;
        end
        if (i_right_count > CNT_W'(MAX_RIGHT_POINTS)) begin
            w_item.count = CNT_W'(MAX_RIGHT_POINTS);
        end else begin
            w_item.count = i_right_count;
        end
    end

    assign o_busy    = (r_cnt == 2'd2);
    assign w_push    = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rptr];

    always_comb begin
        n_wptr = r_wptr ^ w_push;
        n_rptr = r_rptr ^ w_pop;
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

endmodule
`default_nettype wire

@@ sv/skmm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Match mask back end
// Holds the right keypoint table and scans it one entry per cycle.
// ----------------------------------------------------------------------------
module skmm_back
    import skmm_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cfg         i_cfg,
    input  wire          i_q_valid,
    input  t_item        i_q_item,
    output logic         o_q_pop,
    output logic         o_valid,
    output logic [63:0]  o_row_mask
);

    t_entry              r_mem [MAX_RIGHT_POINTS];
    t_entry              r_rd_data;
    logic                r_run;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_last;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_rd_last;
    logic                r_done;
    logic [MASK_W-1:0]   r_mask;
    logic [15:0]         r_lx, r_ly, r_ls;
    logic [14:0]         r_la;

    logic                w_pop;
    logic                w_store;
    logic                w_test;
    t_entry              w_wr;
    logic [15:0]         w_dy;
    logic [14:0]         w_da, w_dw, w_dmin;
    logic [15:0]         w_big, w_small;
    logic [27:0]         w_lhs, w_rhs;
    logic                w_pass;

    assign o_q_pop = !r_run && !r_rd_vld;
    assign w_pop   = o_q_pop && i_q_valid;
    assign w_store = w_pop && (i_q_item.action == ACT_STORE)
                     && ({1'b0, i_q_item.slot} < CNT_W'(MAX_RIGHT_POINTS));
    assign w_test  = w_pop && (i_q_item.action == ACT_TEST);

    always_comb begin
        w_wr.x     = i_q_item.x;
        w_wr.y     = i_q_item.y;
        w_wr.angle = i_q_item.angle;
        w_wr.size  = i_q_item.size;
    end

    // Table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[i_q_item.slot[IDX_W-1:0]] <= w_wr;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // Pair checks on the entry read in the previous cycle.
    always_comb begin
        w_dy = (r_ly >= r_rd_data.y) ? (r_ly - r_rd_data.y) : (r_rd_data.y - r_ly);
        w_da = (r_la >= r_rd_data.angle) ? (r_la - r_rd_data.angle)
                                         : (r_rd_data.angle - r_la);
        w_dw   = FULL_TURN - w_da;
        w_dmin = (w_dw < w_da) ? w_dw : w_da;
        if (r_ls > r_rd_data.size) begin
            w_big   = r_ls;
            w_small = r_rd_data.size;
        end else begin
            w_big   = r_rd_data.size;
            w_small = r_ls;
        end
        w_lhs  = {4'd0, w_big, 8'd0};
        w_rhs  = 28'(i_cfg.max_ratio) * 28'(w_small);
        w_pass = (w_dy <= i_cfg.max_y)
                 && (w_dmin <= {1'b0, i_cfg.max_angle})
                 && (r_lx >= r_rd_data.x)
                 && (r_ls != 16'd0) && (r_rd_data.size != 16'd0)
                 && (w_lhs <= w_rhs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_rd_vld <= r_run;
            r_done   <= (r_rd_vld && r_rd_last)
                        || (w_test && (i_q_item.count == '0));
            if (w_test && (i_q_item.count != '0)) begin
                r_run <= 1'b1;
            end else if (r_run && (r_idx == r_last)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_test) begin
            r_idx  <= '0;
            r_last <= IDX_W'(i_q_item.count - CNT_W'(1));
            r_lx   <= i_q_item.x;
            r_ly   <= i_q_item.y;
            r_la   <= i_q_item.angle;
            r_ls   <= i_q_item.size;
        end else if (r_run) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_rd_idx  <= r_idx;
        r_rd_last <= (r_idx == r_last);
        if (w_test) begin
            r_mask <= '0;
        end else if (r_rd_vld) begin
            r_mask[r_rd_idx] <= w_pass;
        end
    end

    assign o_valid    = r_done;
    assign o_row_mask = r_mask;

endmodule
`default_nettype wire

@@ sv/stereo_keypoint_match_mask_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo keypoint match mask unit
// Stores right-image keypoints and answers each left keypoint with a mask row.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where i_start is high and o_busy is low.
// A store item writes one table entry and gives no result. A test item gives
// exactly one result: o_valid is high for one cycle with o_row_mask, and the
// receiver cannot stall it, so it must take the mask in that very cycle.
// The table has a single read port, so a test scans one entry per cycle.
// When the scan is idle, an item leaves the queue at the edge after it was
// taken. For a test with a count above zero, the back end reads the table
// entries in turn and checks each pair on the registered read data; o_valid
// rises once the last entry has been checked. With a count of zero, o_valid
// rises at the edge where the item leaves the queue. The scan takes the next
// item at the edge after o_valid rises. A store needs no scan.
// A two-item queue separates intake from the scan, so o_busy rises only when
// two items wait. Configuration registers are to be written through the APB-style
// port only while no work is outstanding; the block itself does not enforce
// this. Register 0 is the y limit, 1 the angle limit and 2 the size ratio, at
// byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module stereo_keypoint_match_mask_unit
    import skmm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Item channel
    input  wire         i_start,
    output logic        o_busy,
    input  wire         i_action,
    input  wire  [5:0]  i_slot,
    input  wire  [15:0] i_point_x,
    input  wire  [15:0] i_point_y,
    input  wire  [14:0] i_point_angle,
    input  wire  [15:0] i_point_size,
    input  wire  [6:0]  i_right_count,
    // Result channel
    output logic        o_valid,
    output logic [63:0] o_row_mask,
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   r_cfg;
    logic   w_wr;
    logic   w_q_valid;
    t_item  w_q_item;
    logic   w_q_pop;

    // Register file: writes complete in the access cycle, reads are direct.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_y     <= 16'd32;
            r_cfg.max_angle <= 14'd320;
            r_cfg.max_ratio <= 12'd384;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MAX_Y:     r_cfg.max_y     <= pwdata[15:0];
                REG_MAX_ANGLE: r_cfg.max_angle <= pwdata[13:0];
                REG_MAX_RATIO: r_cfg.max_ratio <= pwdata[11:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_Y:     prdata = {16'd0, r_cfg.max_y};
            REG_MAX_ANGLE: prdata = {18'd0, r_cfg.max_angle};
            REG_MAX_RATIO: prdata = {20'd0, r_cfg.max_ratio};
            default:       prdata = 32'd0;
        endcase
    end

    // Front end: intake, angle folding, count clamping and the item queue.
    skmm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_action      (i_action),
        .i_slot        (i_slot),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_angle (i_point_angle),
        .i_point_size  (i_point_size),
        .i_right_count (i_right_count),
        .o_busy        (o_busy),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    // Back end: keypoint table and the per-entry scan.
    skmm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_valid    (o_valid),
        .o_row_mask (o_row_mask)
    );

endmodule
`default_nettype wire
